@@ rtl/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants for the rotation matrix to quaternion unit
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int ElemW = 18;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_PIVX  = 2'd1,
		BR_PIVY  = 2'd2,
		BR_PIVZ  = 2'd3
	} branch_t;

endpackage

@@ rtl/rmq_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt
// pipelined rounded integer square root, two result bits per stage
// ----------------------------------------------------------------------------
module rmq_sqrt
	import rmq_pkg::*;
#(
	parameter int IN_W = 40,
	parameter int TAG_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  logic [IN_W-1:0]    n,
	input  logic [TAG_W-1:0]   tag_in,
	output logic               vout,
	output logic [IN_W/2:0]    root,
	output logic [TAG_W-1:0]   tag_out
);

	localparam int RW = (IN_W + 1) / 2;
	localparam int NSTG = (RW + 1) / 2;
	localparam int EW = 2 * RW;
	localparam int REMW = RW + 2;

	logic [NSTG:0]           v_s;
	logic [EW-1:0]           x_s   [NSTG+1];
	logic [RW-1:0]           r_s   [NSTG+1];
	logic [REMW-1:0]         rem_s [NSTG+1];
	logic [TAG_W-1:0]        t_s   [NSTG+1];

	assign x_s[0]   = EW'(n);
	assign r_s[0]   = '0;
	assign rem_s[0] = '0;
	assign t_s[0]   = tag_in;
	assign v_s[0]   = vin;

	for (genvar g = 0; g < NSTG; g++) begin : g_stg
		logic [EW-1:0]   xn;
		logic [RW-1:0]   rn;
		logic [REMW-1:0] remn;
		always_comb begin
			logic [REMW-1:0] rem;
			logic [REMW-1:0] trial;
			logic [RW-1:0]   r;
			logic [EW-1:0]   x;
			rem = rem_s[g];
			r = r_s[g];
			x = x_s[g];
			for (int b = 0; b < 2; b++) begin
				rem = {rem[REMW-3:0], x[EW-1 -: 2]};
				x = {x[EW-3:0], 2'b00};
				trial = {r[REMW-3:0], 2'b01};
				if (rem >= trial) begin
					rem = rem - trial;
					r = {r[RW-2:0], 1'b1};
				end else begin
					r = {r[RW-2:0], 1'b0};
				end
			end
			xn = x;
			rn = r;
			remn = rem;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g+1]   <= xn;
				r_s[g+1]   <= rn;
				rem_s[g+1] <= remn;
				t_s[g+1]   <= t_s[g];
			end
		end
	end

	assign vout    = v_s[NSTG];
	assign tag_out = t_s[NSTG];
	assign root    = (IN_W/2+1)'(r_s[NSTG]) +
		(IN_W/2+1)'(rem_s[NSTG] > REMW'(r_s[NSTG]));

endmodule

@@ rtl/rmq_quot.sv @@
// ----------------------------------------------------------------------------
// rmq_quot
// pipelined restoring divider, rounded to nearest with ties away from zero
// ----------------------------------------------------------------------------
module rmq_quot
	import rmq_pkg::*;
#(
	parameter int NUM_W = 36,
	parameter int DEN_W = 20,
	parameter int TAG_W = 8
) (
	input  logic               clk,
	input  logic               en,
	input  logic [NUM_W-1:0]   num,
	input  logic [DEN_W-1:0]   den,
	input  logic [TAG_W-1:0]   tag_in,
	output logic [NUM_W-1:0]   quot,
	output logic [TAG_W-1:0]   tag_out
);

	localparam int BPS = 2;
	localparam int QB = NUM_W + 1;
	localparam int NSTG = (QB + BPS - 1) / BPS;
	localparam int XW = NSTG * BPS;
	localparam int RW = DEN_W + 2;

	logic [XW-1:0]    x_s [NSTG+1];
	logic [XW-1:0]    q_s [NSTG+1];
	logic [RW-1:0]    r_s [NSTG+1];
	logic [DEN_W-1:0] d_s [NSTG+1];
	logic [TAG_W-1:0] t_s [NSTG+1];

	assign x_s[0] = XW'({num, 1'b0});
	assign q_s[0] = '0;
	assign r_s[0] = '0;
	assign d_s[0] = den;
	assign t_s[0] = tag_in;

	for (genvar g = 0; g < NSTG; g++) begin : g_stg
		logic [XW-1:0] xn;
		logic [XW-1:0] qn;
		logic [RW-1:0] rn;
		always_comb begin
			logic [RW-1:0] rem;
			logic [XW-1:0] x;
			logic [XW-1:0] q;
			rem = r_s[g];
			x = x_s[g];
			q = q_s[g];
			for (int b = 0; b < BPS; b++) begin
				rem = {rem[RW-2:0], x[XW-1]};
				x = {x[XW-2:0], 1'b0};
				if (rem >= RW'(d_s[g])) begin
					rem = rem - RW'(d_s[g]);
					q = {q[XW-2:0], 1'b1};
				end else begin
					q = {q[XW-2:0], 1'b0};
				end
			end
			xn = x;
			qn = q;
			rn = rem;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g+1] <= xn;
				q_s[g+1] <= qn;
				r_s[g+1] <= rn;
				d_s[g+1] <= d_s[g];
				t_s[g+1] <= t_s[g];
			end
		end
	end

	// q holds floor(2*num/den); add the half bit for rounding
	logic [XW:0] qr;
	assign qr      = ({1'b0, q_s[NSTG]} + (XW+1)'(1)) >> 1;
	assign quot    = NUM_W'(qr);
	assign tag_out = t_s[NSTG];

endmodule

@@ rtl/rotation_matrix_to_quaternion_unit.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// converts a 3x3 rotation matrix into a quaternion by Shepperd's method
// ----------------------------------------------------------------------------
// Accepts one matrix per clock while the pipeline advances and returns one
// quaternion per matrix in order. At FRAC_BITS = 16 the pipeline has one input
// stage, then ceil(ceil((FRAC_BITS+20)/2)/2) pipelined square root stages (two
// root bits per stage), one numerator stage, ceil((FRAC_BITS+19)/2) stages of
// three parallel pipelined dividers (two quotient bits per stage) and the
// output register; the whole pipeline advances when the output register is
// free or being taken.
module rotation_matrix_to_quaternion_unit
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22, zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,  // qx qy qz qw
	output logic [2:0]   m_tuser   // branch[1:0] degenerate
);

	localparam int AW = ((FRAC_BITS > ElemW) ? FRAC_BITS : ElemW) + 2;
	localparam int SQ_W = AW + FRAC_BITS;
	localparam int RT_W = SQ_W / 2 + 1;
	localparam int DW = ElemW + 1;
	localparam int NUM_W = DW + FRAC_BITS - 1;
	localparam int TAG_W = 3 * DW + 2 + 1;
	localparam int SD_W = RT_W + 2 + 1 + 1;
	localparam logic signed [AW-1:0] One = AW'(1) <<< FRAC_BITS;

	logic en;
	logic signed [ElemW-1:0] m [9];
	always_comb begin
		for (int e = 0; e < 9; e++) m[e] = s_tdata[e*ElemW +: ElemW];
	end

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: pivot choice, argument and signed differences
	logic              v_s1;
	logic [AW-1:0]     arg_s1;
	logic              dg_s1;
	branch_t           br_s1;
	logic signed [DW-1:0] da_s1, db_s1, dc_s1;

	logic signed [AW-1:0] tr, a;
	logic [1:0] pi;
	branch_t br;
	logic signed [DW-1:0] da, db, dc;
	always_comb begin
		tr = AW'(m[0]) + AW'(m[4]) + AW'(m[8]);
		pi = 2'd0;
		if (m[4] > m[0]) pi = 2'd1;
		if (m[8] > (pi == 2'd1 ? m[4] : m[0])) pi = 2'd2;
		if (tr > 0) begin
			br = BR_TRACE;
			a  = tr + One;
			da = DW'(m[7]) - DW'(m[5]);
			db = DW'(m[2]) - DW'(m[6]);
			dc = DW'(m[3]) - DW'(m[1]);
		end else begin
			case (pi)
				2'd0: begin
					br = BR_PIVX;
					a  = AW'(m[0]) - AW'(m[4]) - AW'(m[8]) + One;
					da = DW'(m[7]) - DW'(m[5]);
					db = DW'(m[3]) + DW'(m[1]);
					dc = DW'(m[6]) + DW'(m[2]);
				end
				2'd1: begin
					br = BR_PIVY;
					a  = AW'(m[4]) - AW'(m[8]) - AW'(m[0]) + One;
					da = DW'(m[2]) - DW'(m[6]);
					db = DW'(m[7]) + DW'(m[5]);
					dc = DW'(m[1]) + DW'(m[3]);
				end
				default: begin
					br = BR_PIVZ;
					a  = AW'(m[8]) - AW'(m[0]) - AW'(m[4]) + One;
					da = DW'(m[3]) - DW'(m[1]);
					db = DW'(m[6]) + DW'(m[2]);
					dc = DW'(m[5]) + DW'(m[7]);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dg_s1  <= (a <= 0);
			arg_s1 <= (a <= 0) ? AW'(1) : a;
			br_s1  <= br;
			da_s1  <= da;
			db_s1  <= db;
			dc_s1  <= dc;
		end
	end

	// square root with differences riding along
	logic [TAG_W-1:0] tag_s1, tag_sq;
	logic             v_sq;
	logic [RT_W-1:0]  root_sq;
	assign tag_s1 = {da_s1, db_s1, dc_s1, br_s1, dg_s1};

	rmq_sqrt #(.IN_W(SQ_W), .TAG_W(TAG_W)) u_sqrt (
		.clk, .arst_n, .en,
		.vin(v_s1),
		.n({arg_s1, FRAC_BITS'(0)}),
		.tag_in(tag_s1),
		.vout(v_sq),
		.root(root_sq),
		.tag_out(tag_sq)
	);

	// stage 2: magnitudes and numerators
	logic              v_s2;
	logic [RT_W-1:0]   root_s2;
	logic [TAG_W-1:0]  tag_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_sq;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			root_s2 <= root_sq;
			tag_s2  <= tag_sq;
		end
	end

	logic signed [DW-1:0] dv [3];
	logic [NUM_W-1:0] nm [3];
	logic [NUM_W-1:0] qq [3];
	assign dv[0] = tag_s2[TAG_W-1 -: DW];
	assign dv[1] = tag_s2[TAG_W-1-DW -: DW];
	assign dv[2] = tag_s2[TAG_W-1-2*DW -: DW];

	// valid travels in its own pipe alongside the dividers
	localparam int QSTG = (NUM_W + 2) / 2;
	logic [QSTG:0] vq;
	assign vq[0] = v_s2;
	for (genvar g = 0; g < QSTG; g++) begin : g_vq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vq[g+1] <= 1'b0;
			end else if (en) begin
				vq[g+1] <= vq[g];
			end
		end
	end

	// side info for the output: signs, root, branch, flag
	logic [RT_W-1:0] rt_o;
	logic [2:0]      sg_o;
	branch_t         br_o;
	logic            dg_o;

	for (genvar c = 0; c < 3; c++) begin : g_div
		localparam int TW = (c == 0) ? SD_W : 1;
		logic [DW-1:0] mag;
		logic [TW-1:0] tag_i, tag_o;
		assign mag = dv[c][DW-1] ? DW'(-dv[c]) : DW'(dv[c]);
		assign nm[c] = NUM_W'({mag, (FRAC_BITS-1)'(0)});
		// first divider also carries root, branch and flag
		if (c == 0) begin : g_side
			assign tag_i = {root_s2, tag_s2[2:0], dv[c][DW-1]};
			assign rt_o  = tag_o[TW-1 -: RT_W];
			assign br_o  = branch_t'(tag_o[3:2]);
			assign dg_o  = tag_o[1];
		end else begin : g_sign
			assign tag_i = dv[c][DW-1];
		end
		assign sg_o[c] = tag_o[0];
		rmq_quot #(.NUM_W(NUM_W), .DEN_W(RT_W), .TAG_W(TW)) u_quot (
			.clk, .en,
			.num(nm[c]),
			.den(root_s2),
			.tag_in(tag_i),
			.quot(qq[c]),
			.tag_out(tag_o)
		);
	end

	function automatic logic [ElemW-1:0] sat(input logic signed [NUM_W+1:0] v);
		logic signed [NUM_W+1:0] hi;
		logic signed [NUM_W+1:0] lo;
		hi = (NUM_W+2)'((1 << (ElemW-1)) - 1);
		lo = -(NUM_W+2)'(1 << (ElemW-1));
		if (v > hi) return hi[ElemW-1:0];
		if (v < lo) return lo[ElemW-1:0];
		return v[ElemW-1:0];
	endfunction

	logic [ElemW-1:0] sq [3];
	logic [ElemW-1:0] piv;
	always_comb begin
		logic signed [NUM_W+1:0] t;
		for (int c = 0; c < 3; c++) begin
			t = (NUM_W+2)'(qq[c]);
			sq[c] = sat(sg_o[c] ? -t : t);
		end
		t = (NUM_W+2)'(({1'b0, rt_o} + (RT_W+1)'(1)) >> 1);
		piv = sat(t);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vq[QSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser <= {dg_o, br_o};
			unique case (br_o)
				BR_TRACE: m_tdata <= {piv, sq[2], sq[1], sq[0]};
				BR_PIVX:  m_tdata <= {sq[0], sq[2], sq[1], piv};
				BR_PIVY:  m_tdata <= {sq[0], sq[1], piv, sq[2]};
				default:  m_tdata <= {sq[0], piv, sq[2], sq[1]};
			endcase
		end
	end

	// ordering: a held result keeps the pipe frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output stage");
	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] != BR_TRACE)
		else $error("trace branch flagged degenerate");

endmodule
